[rtl/core/skvt_pkg.sv]
// ----------------------------------------------------------------------------
// skvt_pkg
// Shared types and status codes for the sorted key/value table.
// ----------------------------------------------------------------------------
package skvt_pkg;

   localparam int KEY_BITS = 32;
   localparam int IN_VALUE_BITS = 32;
   localparam int STATUS_BITS = 3;
   localparam int POSITION_BITS = 8;

   localparam logic [STATUS_BITS-1:0] STATUS_INSERTED  = 3'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_DUPLICATE = 3'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL      = 3'd2;
   localparam logic [STATUS_BITS-1:0] STATUS_FOUND     = 3'd3;
   localparam logic [STATUS_BITS-1:0] STATUS_NOT_FOUND = 3'd4;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   typedef struct packed {
      logic                       op;
      logic signed [KEY_BITS-1:0] key;
      logic [IN_VALUE_BITS-1:0]   value;
   } req_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0]   status;
      logic [IN_VALUE_BITS-1:0] found_value;
      logic [POSITION_BITS-1:0] position;
   } rsp_type;

endpackage

[rtl/core/sorted_key_value_table_core.sv]
// ----------------------------------------------------------------------------
// sorted_key_value_table_core
// Sorted key/value table with binary search lookup and shifting insert.
// ----------------------------------------------------------------------------
//   channel  ports                          direction  word
//   request  req_valid req_stall req_word   in         op, key, value
//   response rsp_valid rsp_stall rsp_word   out        status, found_value, position
//
// one request at a time; a search probes each midpoint through the registered ram read (SEARCH, then PROBE),
// then fetches the lower bound for the check in DECIDE; an insert then shifts each entry at or above the
// insert position up one slot (SHIFT) and writes the new entry (WRITE_NEW).
// synchronous reset clears the entry count and handshake state; ram needs no clearing.
// a stalled response is held in its output register while the next request is taken.
// ----------------------------------------------------------------------------
module sorted_key_value_table_core
   import skvt_pkg::*;
#(
   parameter int CAPACITY = 256,
   parameter int VALUE_BITS = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_word,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_word
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int MW = KEY_BITS + VALUE_BITS;
   localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

   typedef enum logic [2:0] {
      IDLE,
      SEARCH,
      PROBE,
      DECIDE,
      SHIFT,
      WRITE_NEW,
      DONE
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] lo_ff, lo_in;
   logic [CW-1:0] hi_ff, hi_in;
   logic [CW-1:0] mv_ff, mv_in;
   logic          pend_ff, pend_in;
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   req_type       req_ff, req_in;
   rsp_type       result_ff, result_in;
   rsp_type       rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic          ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   logic [MW-1:0] ram_wr_data;
   logic [AW-1:0] ram_rd_addr;
   logic [MW-1:0] ram_rd_data;

   logic [CW-1:0]              mid;
   logic signed [KEY_BITS-1:0] rd_key;
   logic [63:0]                rd_value_ext;
   logic [63:0]                new_value_ext;
   logic [31:0]                lo_ext;
   logic                       hit;

   assign mid           = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign rd_key        = ram_rd_data[MW-1:VALUE_BITS];
   assign rd_value_ext  = 64'(ram_rd_data[VALUE_BITS-1:0]);
   assign new_value_ext = 64'(req_ff.value);
   assign lo_ext        = 32'(lo_ff);
   assign hit           = (lo_ff < count_ff) && (rd_key == req_ff.key);

   skvt_ram #(
      .WIDTH(MW),
      .DEPTH(CAPACITY)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mv_in        = mv_ff;
      pend_in      = pend_ff;
      wr_ptr_in    = wr_ptr_ff;
      req_in       = req_ff;
      result_in    = result_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = wr_ptr_ff;
      ram_wr_data  = ram_rd_data;
      ram_rd_addr  = '0;

      unique case (state_ff)
         IDLE: begin
            if (req_valid) begin
               req_in   = req_word;
               lo_in    = '0;
               hi_in    = count_ff;
               state_in = SEARCH;
            end
         end
         SEARCH: begin
            if (lo_ff < hi_ff) begin
               ram_rd_addr = mid[AW-1:0];
               state_in    = PROBE;
            end else begin
               // lower bound reached, fetch it for the equality check
               ram_rd_addr = (lo_ff < count_ff) ? lo_ff[AW-1:0] : '0;
               state_in    = DECIDE;
            end
         end
         PROBE: begin
            if (rd_key < req_ff.key) begin
               lo_in = mid + CW'(1);
            end else begin
               hi_in = mid;
            end
            state_in = SEARCH;
         end
         DECIDE: begin
            result_in.found_value = '0;
            result_in.position    = lo_ext[POSITION_BITS-1:0];
            state_in              = DONE;
            if (req_ff.op == OP_LOOKUP) begin
               if (hit) begin
                  result_in.status      = STATUS_FOUND;
                  result_in.found_value = rd_value_ext[IN_VALUE_BITS-1:0];
               end else begin
                  result_in.status = STATUS_NOT_FOUND;
               end
            end else if (hit) begin
               result_in.status = STATUS_DUPLICATE;
            end else if (count_ff == FULL_COUNT) begin
               result_in.status   = STATUS_FULL;
               result_in.position = '0;
            end else begin
               result_in.status = STATUS_INSERTED;
               mv_in            = count_ff;
               pend_in          = 1'b0;
               state_in         = SHIFT;
            end
         end
         SHIFT: begin
            // read entry mv-1 while writing the one fetched last cycle
            if (pend_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = wr_ptr_ff;
               ram_wr_data = ram_rd_data;
            end
            if (mv_ff > lo_ff) begin
               ram_rd_addr = AW'(mv_ff - CW'(1));
               wr_ptr_in   = mv_ff[AW-1:0];
               mv_in       = mv_ff - CW'(1);
               pend_in     = 1'b1;
            end else begin
               pend_in  = 1'b0;
               state_in = WRITE_NEW;
            end
         end
         WRITE_NEW: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = lo_ff[AW-1:0];
            ram_wr_data = {req_ff.key, new_value_ext[VALUE_BITS-1:0]};
            count_in    = count_ff + CW'(1);
            state_in    = DONE;
         end
         DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in       = result_ff;
               rsp_valid_in = 1'b1;
               state_in     = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      mv_ff     <= mv_in;
      wr_ptr_ff <= wr_ptr_in;
      req_ff    <= req_in;
      result_ff <= result_in;
      rsp_ff    <= rsp_in;
   end

   assign req_stall = (state_ff != IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("entry count above capacity");

   a_insert_not_full: assert property (@(posedge clock) disable iff (reset)
      state_ff == WRITE_NEW |-> count_ff < FULL_COUNT)
      else $error("insert into full table");

   a_decide_after_search: assert property (@(posedge clock) disable iff (reset)
      state_ff == DECIDE |-> $past(state_ff) == SEARCH)
      else $error("decide without finished search");

   a_shift_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SHIFT && ram_wr_en && mv_ff > lo_ff) |-> ram_wr_addr != ram_rd_addr)
      else $error("shift read and write hit the same entry");
`endif

endmodule

[rtl/core/skvt_ram.sv]
// ----------------------------------------------------------------------------
// skvt_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module skvt_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
